/* hdl/cc_pkg.sv */
// Shared types, constants and helper functions for the ChaCha20 stream cipher unit.
// No dependencies; cc_front, cc_core, cc_back and the top level import this package.
package cc_pkg;

    localparam int DEF_DOUBLE_ROUNDS = 10;
    localparam int BLOCK_BYTES       = 64;
    localparam int NUM_REGS          = 7;
    localparam int REG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int Q_DEPTH           = 4;
    localparam int Q_PTR_W           = $clog2(Q_DEPTH);

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam int ROT_A = 16;
    localparam int ROT_B = 12;
    localparam int ROT_C = 8;
    localparam int ROT_D = 7;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_KEY0     = 3'd0,
        REG_KEY1     = 3'd1,
        REG_KEY2     = 3'd2,
        REG_KEY3     = 3'd3,
        REG_NONCE_LO = 3'd4,
        REG_NONCE_HI = 3'd5,
        REG_START    = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        BK_EMPTY,
        BK_CALC,
        BK_SERVE
    } t_bk_st;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_RUN,
        CORE_ADD
    } t_core_st;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_item;

    typedef struct packed {
        logic [7:0][31:0] key;
        logic [2:0][31:0] nonce;
    } t_key_state;

    // configuration write event seen by the back end
    typedef struct packed {
        logic        hit;
        logic [31:0] start;
    } t_cfg_evt;

    typedef struct packed {
        logic        start;
        logic [31:0] ctr;
    } t_core_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_core_sts;

    function automatic logic [31:0] rotl32(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [15:0][31:0] init_state(t_key_state ks, logic [31:0] ctr);
        logic [15:0][31:0] s;
        s[0] = SIGMA0;
        s[1] = SIGMA1;
        s[2] = SIGMA2;
        s[3] = SIGMA3;
        for (int i = 0; i < 8; i++) begin
            s[4 + i] = ks.key[i];
        end
        s[12] = ctr;
        s[13] = ks.nonce[0];
        s[14] = ks.nonce[1];
        s[15] = ks.nonce[2];
        return s;
    endfunction

endpackage

/* hdl/cc_in_if.sv */
// Input channel of the cipher unit: valid/ready handshake carrying one data byte.
// No dependencies.
interface cc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

/* hdl/cc_out_if.sv */
// Output channel of the cipher unit: valid/ready handshake carrying one result byte.
// No dependencies.
interface cc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* hdl/cc_front.sv */
// Front end: accepts input transactions into a short queue ahead of the keystream back end.
// Depends on cc_pkg and cc_in_if.
module cc_front
    import cc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    cc_in_if.sink    i_data,
    output logic     o_q_valid,
    output t_item    o_q_item,
    input  logic     i_q_pop
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;
    logic               w_push;

    assign i_data.ready = (r_cnt != (Q_PTR_W + 1)'(Q_DEPTH));
    assign w_push       = i_data.valid && i_data.ready;
    assign o_q_valid    = (r_cnt != '0);
    assign o_q_item     = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= '{data_byte: i_data.data_byte,
                             end_of_message: i_data.end_of_message};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({w_push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* hdl/cc_core.sv */
// ChaCha20 block function: one quarter-round step on all four lanes per cycle, then feed-forward.
// Depends on cc_pkg.
module cc_core
    import cc_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DEF_DOUBLE_ROUNDS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_key_state        i_key,
    input  t_core_req         i_req,
    output t_core_sts         o_sts,
    output logic [15:0][31:0] o_words
);

    localparam int RW = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    t_core_st          r_st;
    t_core_st          n_st;
    logic [1:0]        r_step;
    logic              r_diag;
    logic [RW-1:0]     r_round;
    logic [31:0]       r_ctr;
    logic [15:0][31:0] r_w;
    logic [15:0][31:0] n_w;
    logic [15:0][31:0] w_step;
    logic [15:0][31:0] w_init;
    logic              w_last;

    assign w_init  = init_state(i_key, r_ctr);
    assign w_last  = (r_step == 2'd3) && r_diag && (r_round == RW'(DOUBLE_ROUNDS - 1));
    assign o_words = r_w;

    // four independent quarter-round lanes; diagonal pass rotates the b, c, d rows
    always_comb begin
        logic [3:0]  ia;
        logic [3:0]  ib;
        logic [3:0]  ic;
        logic [3:0]  id;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        w_step = r_w;
        for (int l = 0; l < 4; l++) begin
            ia = {2'b00, 2'(l)};
            ib = {2'b01, 2'(l) + 2'(r_diag)};
            ic = {2'b10, 2'(l) + {r_diag, 1'b0}};
            id = {2'b11, 2'(l) + {r_diag, r_diag}};
            a  = r_w[ia];
            b  = r_w[ib];
            c  = r_w[ic];
            d  = r_w[id];
            case (r_step)
                2'd0: begin
                    a = a + b;
                    d = rotl32(d ^ a, ROT_A);
                end
                2'd1: begin
                    c = c + d;
                    b = rotl32(b ^ c, ROT_B);
                end
                2'd2: begin
                    a = a + b;
                    d = rotl32(d ^ a, ROT_C);
                end
                default: begin
                    c = c + d;
                    b = rotl32(b ^ c, ROT_D);
                end
            endcase
            w_step[ia] = a;
            w_step[ib] = b;
            w_step[ic] = c;
            w_step[id] = d;
        end
    end

    always_comb begin
        n_w = r_w;
        case (r_st)
            CORE_IDLE: begin
                if (i_req.start) begin
                    n_w = init_state(i_key, i_req.ctr);
                end
            end
            CORE_RUN: n_w = w_step;
            CORE_ADD: begin
                for (int i = 0; i < 16; i++) begin
                    n_w[i] = r_w[i] + w_init[i];
                end
            end
            default: n_w = r_w;
        endcase
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            CORE_IDLE: if (i_req.start) n_st = CORE_RUN;
            CORE_RUN:  if (w_last) n_st = CORE_ADD;
            CORE_ADD:  n_st = CORE_IDLE;
            default:   n_st = CORE_IDLE;
        endcase
    end

    always_comb begin
        o_sts.busy = (r_st != CORE_IDLE);
        o_sts.done = (r_st == CORE_ADD);
    end

    always_ff @(posedge i_clk) begin
        r_w <= n_w;
        if (r_st == CORE_IDLE && i_req.start) begin
            r_ctr <= i_req.ctr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= CORE_IDLE;
            r_step  <= '0;
            r_diag  <= 1'b0;
            r_round <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == CORE_IDLE) begin
                r_step  <= '0;
                r_diag  <= 1'b0;
                r_round <= '0;
            end else if (r_st == CORE_RUN) begin
                r_step <= r_step + 1'b1;
                if (r_step == 2'd3) begin
                    r_diag <= ~r_diag;
                    if (r_diag) begin
                        r_round <= r_round + 1'b1;
                    end
                end
            end
        end
    end

endmodule

/* hdl/cc_back.sv */
// Back end: keeps the block counter, requests blocks from the core and XORs queued bytes.
// Depends on cc_pkg, cc_out_if and cc_core.
module cc_back
    import cc_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DEF_DOUBLE_ROUNDS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_key_state i_key,
    input  t_cfg_evt   i_cfg,
    input  logic       i_q_valid,
    input  t_item      i_q_item,
    output logic       o_q_pop,
    cc_out_if.source   o_data
);

    t_bk_st            r_st;
    t_bk_st            n_st;
    logic [5:0]        r_pos;
    logic [31:0]       r_ctr;
    logic              r_ovalid;
    logic [7:0]        r_obyte;
    logic              r_olast;
    t_core_req         w_req;
    t_core_sts         w_sts;
    logic [15:0][31:0] w_words;
    logic [31:0]       w_word;
    logic [7:0]        w_ks;
    logic              w_out_free;
    logic              w_block_end;

    cc_core #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_key   (i_key),
        .i_req   (w_req),
        .o_sts   (w_sts),
        .o_words (w_words)
    );

    assign w_word      = w_words[r_pos[5:2]];
    assign w_ks        = w_word[{r_pos[1:0], 3'b000} +: 8];
    assign w_out_free  = !r_ovalid || o_data.ready;
    assign w_block_end = i_q_item.end_of_message || (r_pos == 6'(BLOCK_BYTES - 1));

    assign o_data.valid    = r_ovalid;
    assign o_data.out_byte = r_obyte;
    assign o_data.out_last = r_olast;

    always_comb begin
        w_req.start = (r_st == BK_EMPTY) && i_q_valid && !w_sts.busy && !i_cfg.hit;
        w_req.ctr   = r_ctr;
        o_q_pop     = (r_st == BK_SERVE) && i_q_valid && w_out_free && !i_cfg.hit;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            BK_EMPTY: if (w_req.start) n_st = BK_CALC;
            BK_CALC:  if (w_sts.done) n_st = BK_SERVE;
            BK_SERVE: if (o_q_pop && w_block_end) n_st = BK_EMPTY;
            default:  n_st = BK_EMPTY;
        endcase
        // a register write drops the buffered block
        if (i_cfg.hit) begin
            n_st = BK_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_obyte <= i_q_item.data_byte ^ w_ks;
            r_olast <= i_q_item.end_of_message;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= BK_EMPTY;
            r_pos    <= '0;
            r_ctr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_st <= n_st;
            if (i_cfg.hit) begin
                r_pos <= '0;
                r_ctr <= i_cfg.start;
            end else begin
                if (w_req.start) begin
                    r_ctr <= r_ctr + 1'b1;
                end
                if (o_q_pop) begin
                    r_pos <= w_block_end ? '0 : r_pos + 1'b1;
                end
            end
            if (o_q_pop) begin
                r_ovalid <= 1'b1;
            end else if (o_data.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

/* hdl/chacha20_stream_cipher_unit.sv */
// ChaCha20 stream cipher: each byte taken on i_data leaves on o_data XORed with the keystream.
// The first byte of every 64-byte block waits for the block function: the round unit does
// one quarter-round step on four lanes per cycle, then a feed-forward step. The other bytes
// of the block go through at one per cycle while bytes are queued and the output is not
// stalled. A byte marked end_of_message closes its block, so the next byte always waits for
// a fresh block. A four-entry queue takes input while a block is computed. Configuration
// writes (index 0..6) are to be made while the unit is idle; the unit does not enforce this.
// Each one reloads the block counter and drops the block.
// Depends on cc_pkg, cc_in_if, cc_out_if, cc_front and cc_back.
module chacha20_stream_cipher_unit
    import cc_pkg::*;
#(
    parameter int DOUBLE_ROUNDS = DEF_DOUBLE_ROUNDS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    cc_in_if.sink                 i_data,
    cc_out_if.source              o_data
);

    logic [63:0] r_key0;
    logic [63:0] r_key1;
    logic [63:0] r_key2;
    logic [63:0] r_key3;
    logic [63:0] r_nonce_lo;
    logic [31:0] r_nonce_hi;
    logic [31:0] r_start;
    t_key_state  w_key;
    t_cfg_evt    w_cfg;
    logic        w_q_valid;
    t_item       w_q_item;
    logic        w_q_pop;

    always_comb begin
        w_key.key[0]   = r_key0[31:0];
        w_key.key[1]   = r_key0[63:32];
        w_key.key[2]   = r_key1[31:0];
        w_key.key[3]   = r_key1[63:32];
        w_key.key[4]   = r_key2[31:0];
        w_key.key[5]   = r_key2[63:32];
        w_key.key[6]   = r_key3[31:0];
        w_key.key[7]   = r_key3[63:32];
        w_key.nonce[0] = r_nonce_lo[31:0];
        w_key.nonce[1] = r_nonce_lo[63:32];
        w_key.nonce[2] = r_nonce_hi;
        w_cfg.hit      = i_cfg_we && (i_cfg_idx < REG_IDX_W'(NUM_REGS));
        w_cfg.start    = (i_cfg_idx == REG_START) ? i_cfg_wdata[31:0] : r_start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0     <= '0;
            r_key1     <= '0;
            r_key2     <= '0;
            r_key3     <= '0;
            r_nonce_lo <= '0;
            r_nonce_hi <= '0;
            r_start    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_KEY0:     r_key0     <= i_cfg_wdata;
                REG_KEY1:     r_key1     <= i_cfg_wdata;
                REG_KEY2:     r_key2     <= i_cfg_wdata;
                REG_KEY3:     r_key3     <= i_cfg_wdata;
                REG_NONCE_LO: r_nonce_lo <= i_cfg_wdata;
                REG_NONCE_HI: r_nonce_hi <= i_cfg_wdata[31:0];
                REG_START:    r_start    <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    cc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_data    (i_data),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    cc_back #(
        .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_key     (w_key),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_data    (o_data)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("queue popped while empty");

    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |=> o_data.valid)
        else $error("popped byte did not reach the output register");

    a_cfg_drops_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg.hit |=> !w_q_pop)
        else $error("byte served from a block dropped by a register write");

endmodule
